/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

/* rtl/nlsu_pkg.sv */
// ----------------------------------------------------------------------------
// nlsu_pkg
// Shared widths, constants and the divider stage type of the natural log series unit.
// ----------------------------------------------------------------------------
`default_nettype none
package nlsu_pkg;
  localparam int unsigned X_W     = 32;
  localparam int unsigned LOG_W   = 32;
  localparam int unsigned IN_TW   = 32;
  localparam int unsigned OUT_TW  = 40;
  localparam int unsigned Q_W     = 30;  // magnitude bits of Q1.30 values
  localparam int unsigned DEN_W   = 33;
  localparam int unsigned SUM_W   = 40;
  localparam logic [X_W-1:0] ONE_Q16 = 32'h0001_0000;

  // One restoring-division stage: zero and sign flags, remainder, divisor,
  // dividend bits not yet consumed and quotient bits produced so far.
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   quo;
  } div_stage_t;
endpackage
`default_nettype wire

/* rtl/natural_log_series_unit.sv */
// ----------------------------------------------------------------------------
// natural_log_series_unit
// Pipelined fixed-point natural logarithm by the truncated atanh series.
// ----------------------------------------------------------------------------
// The unit takes one unsigned Q16.16 operand x per transaction and returns
// ln(x) in signed Q8.24 as 2 * sum of a^k/k over odd k below SERIES_LIMIT,
// with a = (x-1)/(x+1). A zero operand returns minus_infinity set and a zero
// value. One transaction is accepted every cycle while the output is not
// stalled. The pipeline is the input stage, the 30-stage bit-per-stage
// restoring divider that forms a, the a^2 multiplier, one multiplier stage
// per series term and the output stage. Results come back in input order.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall holds every stage in place.
`default_nettype none
module natural_log_series_unit #(
  parameter int unsigned SERIES_LIMIT = 20
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] x_value
  input  wire logic [nlsu_pkg::IN_TW-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // [31:0] log_value, [32] minus_infinity, [39:33] zero
  output logic [nlsu_pkg::OUT_TW-1:0]    m_axis_tdata_o
);
  import nlsu_pkg::*;

  localparam int unsigned NT    = SERIES_LIMIT / 2;  // number of odd k terms
  localparam int unsigned DIV_N = Q_W;

  // Advance the whole pipeline when the output slot frees up.
  logic adv;
  logic out_valid_q;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Input stage: form numerator, divisor and the top of the rounded dividend.
  logic             in_valid_q;
  div_stage_t       in_q;
  div_stage_t       in_d;
  logic [X_W-1:0]   x;
  logic [X_W-1:0]   num;
  logic [DEN_W-1:0] den;
  logic [X_W-1:0]   half;

  always_comb begin
    x    = s_axis_tdata_i[X_W-1:0];
    num  = (x < ONE_Q16) ? (ONE_Q16 - x) : (x - ONE_Q16);
    den  = {1'b0, x} + {1'b0, ONE_Q16};
    half = den[DEN_W-1:1];
    in_d.zero = (x == '0);
    in_d.neg  = (x < ONE_Q16);
    in_d.den  = den;
    in_d.rem  = {1'b0, num} + {{(DEN_W-2){1'b0}}, half[X_W-1:Q_W]};
    in_d.low  = half[Q_W-1:0];
    in_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_d;
    end
  end

  // Divider: one quotient bit per stage, remainder kept below the divisor.
  logic       div_valid_q [DIV_N];
  div_stage_t div_q       [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic       prev_valid;
    div_stage_t prev;
    div_stage_t nxt;
    logic [DEN_W:0] trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign prev_valid = in_valid_q;
      assign prev       = in_q;
    end else begin : g_rest
      assign prev_valid = div_valid_q[i-1];
      assign prev       = div_q[i-1];
    end

    always_comb begin
      trial    = {prev.rem, prev.low[Q_W-1]};
      ge       = (trial >= {1'b0, prev.den});
      nxt      = prev;
      nxt.rem  = ge ? DEN_W'(trial - {1'b0, prev.den}) : trial[DEN_W-1:0];
      nxt.low  = {prev.low[Q_W-2:0], 1'b0};
      nxt.quo  = {prev.quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[i] <= 1'b0;
      end else if (adv) begin
        div_valid_q[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[i] <= nxt;
      end
    end
  end

  // Series stages: index 0 holds |a| and a^2, stage j+1 has added term j-1
  // and formed term j and the next odd power.
  logic             ser_valid_q [NT+1];
  logic             ser_zero_q  [NT+1];
  logic             ser_neg_q   [NT+1];
  logic [Q_W-1:0]   ser_p_q     [NT+1];
  logic [Q_W-1:0]   ser_a2_q    [NT+1];
  logic [Q_W-1:0]   ser_term_q  [NT+1];
  logic [SUM_W-1:0] ser_sum_q   [NT+1];

  logic [2*Q_W-1:0] sq_prod;
  logic [2*Q_W:0]   sq_rnd;
  assign sq_prod = div_q[DIV_N-1].quo * div_q[DIV_N-1].quo;
  assign sq_rnd  = {1'b0, sq_prod} + (61'd1 << (Q_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q[0] <= 1'b0;
    end else if (adv) begin
      ser_valid_q[0] <= div_valid_q[DIV_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ser_zero_q[0] <= div_q[DIV_N-1].zero;
      ser_neg_q[0]  <= div_q[DIV_N-1].neg;
      ser_p_q[0]    <= div_q[DIV_N-1].quo;
      ser_a2_q[0]   <= sq_rnd[2*Q_W-1:Q_W];
      ser_term_q[0] <= '0;
      ser_sum_q[0]  <= '0;
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int unsigned K = 2 * j + 1;
    localparam logic [Q_W:0] RECIP = (Q_W+1)'((64'd1073741824 + 64'(K / 2)) / 64'(K));
    logic [2*Q_W:0]   t_prod;
    logic [2*Q_W+1:0] t_rnd;
    logic [2*Q_W-1:0] p_prod;
    logic [2*Q_W:0]   p_rnd;

    assign t_prod = ser_p_q[j] * RECIP;
    assign t_rnd  = {1'b0, t_prod} + (62'd1 << (Q_W - 1));
    assign p_prod = ser_p_q[j] * ser_a2_q[j];
    assign p_rnd  = {1'b0, p_prod} + (61'd1 << (Q_W - 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ser_valid_q[j+1] <= 1'b0;
      end else if (adv) begin
        ser_valid_q[j+1] <= ser_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ser_zero_q[j+1] <= ser_zero_q[j];
        ser_neg_q[j+1]  <= ser_neg_q[j];
        ser_a2_q[j+1]   <= ser_a2_q[j];
        ser_p_q[j+1]    <= p_rnd[2*Q_W-1:Q_W];
        ser_term_q[j+1] <= t_rnd[2*Q_W-1:Q_W];
        ser_sum_q[j+1]  <= ser_sum_q[j] + {{(SUM_W-Q_W){1'b0}}, ser_term_q[j]};
      end
    end
  end

  // Output stage: add the last term, round to Q8.24, apply the sign.
  logic [SUM_W-1:0]  fin_sum;
  logic [LOG_W-1:0]  mag;
  logic [LOG_W-1:0]  log_d;
  logic [OUT_TW-1:0] out_d;
  logic [OUT_TW-1:0] out_q;

  always_comb begin
    fin_sum = ser_sum_q[NT] + {{(SUM_W-Q_W){1'b0}}, ser_term_q[NT]} + SUM_W'(16);
    mag     = fin_sum[LOG_W+4:5];
    if (ser_zero_q[NT]) begin
      log_d = '0;
    end else if (ser_neg_q[NT]) begin
      log_d = LOG_W'(0) - mag;
    end else begin
      log_d = mag;
    end
    out_d = {{(OUT_TW-LOG_W-1){1'b0}}, ser_zero_q[NT], log_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ser_valid_q[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
endmodule
`default_nettype wire

/* rtl/nlsu_checker.sv */
// ----------------------------------------------------------------------------
// nlsu_checker
// Port-level checks of the natural log series unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module nlsu_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tready_o,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [nlsu_pkg::OUT_TW-1:0] m_axis_tdata_o
);
  import nlsu_pkg::*;

  `ASSERT_RST(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `ASSERT_RST(a_minf_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[LOG_W] |-> m_axis_tdata_o[LOG_W-1:0] == '0)
  `ASSERT_RST(a_pad, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TW-1:LOG_W+1] == '0)
  `ASSERT_RST(a_ready, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)
endmodule

bind natural_log_series_unit nlsu_checker u_nlsu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

/* tb/sv/natural_log_series_unit_tb.sv */
// ----------------------------------------------------------------------------
// natural_log_series_unit_tb
// Self-checking bench for the pipelined natural log series unit.
// ----------------------------------------------------------------------------
// Feeds Q16.16 operands through the input stream in random bursts, stalls the
// output stream on its own pattern and compares every log result and
// minus-infinity flag with a bit-exact fixed-point predictor of the series.
`default_nettype none
module natural_log_series_unit_tb;
  import nlsu_pkg::*;

  localparam int unsigned SERIES_LIMIT = 20;
  localparam int unsigned LATENCY      = SERIES_LIMIT / 2 + 33;
  localparam int unsigned WATCHDOG_MAX = 20000;
  localparam int unsigned N_RANDOM     = 1300;

  typedef struct packed {
    logic [LOG_W-1:0] log_value;
    logic             minus_infinity;
  } log_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [IN_TW-1:0]    s_axis_tdata_i;   // [31:0] x_value
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OUT_TW-1:0]   m_axis_tdata_o;   // [31:0] log_value, [32] minus_infinity

  natural_log_series_unit #(.SERIES_LIMIT(SERIES_LIMIT)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  logic [X_W-1:0] pending_x_q[$];
  log_result_t    expected_log_q[$];
  int unsigned    error_count;
  int unsigned    accepted_in;
  int unsigned    accepted_out;
  int unsigned    idle_cycles;
  int unsigned    neg_count;
  int unsigned    inf_count;
  bit             stimulus_done;
  bit             long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Round to nearest in Q1.30.
  function automatic logic [63:0] q30_mul(input logic [63:0] x, input logic [63:0] y);
    return (x * y + 64'd536870912) >> 30;
  endfunction

  // Predict one result: |a| = |x-1|/(x+1), then twice the odd-power series.
  function automatic log_result_t predict_log(input logic [X_W-1:0] x);
    log_result_t r;
    logic [63:0] num, den, amag, a2, pw, sum, mag, recip;
    logic neg;
    r.log_value      = '0;
    r.minus_infinity = 1'b0;
    if (x == '0) begin
      r.minus_infinity = 1'b1;
      return r;
    end
    neg  = (x < ONE_Q16);
    num  = neg ? 64'(ONE_Q16 - x) : 64'(x - ONE_Q16);
    den  = 64'(x) + 64'(ONE_Q16);
    amag = ((num << 30) + (den >> 1)) / den;
    a2   = q30_mul(amag, amag);
    pw   = amag;
    sum  = '0;
    for (int k = 1; k < SERIES_LIMIT; k += 2) begin
      recip = (64'd1073741824 + 64'(k >> 1)) / 64'(k);
      sum  += q30_mul(pw, recip);
      pw    = q30_mul(pw, a2);
    end
    mag = (sum + 64'd16) >> 5;
    r.log_value = neg ? 32'(32'd0 - mag[31:0]) : mag[31:0];
    return r;
  endfunction

  // Operand mix: some near one, some anywhere, some at the edges.
  function automatic logic [X_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return $urandom_range(0, 255);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      3:       return ONE_Q16 + $urandom_range(0, 511) - 256;
      4:       return $urandom_range(1, 32'h0000_FFFF);
      5:       return 32'h0001_0000 + ($urandom & 32'h000F_FFFF);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [X_W-1:0] directed[$];
    rst_ni          = 1'b0;
    stimulus_done   = 1'b0;
    error_count     = 0;
    directed = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, ONE_Q16,
                 ONE_Q16 - 1, ONE_Q16 + 1, 32'h0000_8000, 32'h0002_0000,
                 32'h0000_4000, 32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0002_B7E1, 32'h0000_5E2D,
                 32'h00FF_0000, 32'h0000_0100};
    foreach (directed[i]) pending_x_q.push_back(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) pending_x_q.push_back(pick_operand());
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait for the last operand to be taken, then for its result to drain.
    while (pending_x_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_log_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    stimulus_done = 1'b1;
  end

  // Driver: bursts of random length, random gaps; hold the item until taken.
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      burst_left      <= $urandom_range(1, 40);
      gap_left        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_log_q.push_back(predict_log(s_axis_tdata_i));
        accepted_in <= accepted_in + 1;
        if (s_axis_tdata_i == '0) inf_count <= inf_count + 1;
        else if (s_axis_tdata_i < ONE_Q16) neg_count <= neg_count + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left        <= gap_left - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_x_q.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_x_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once inputs are flowing.
  int unsigned hold_count;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_count      <= 0;
      long_hold       <= 1'b0;
    end else if (!long_hold && accepted_in == 300) begin
      long_hold       <= 1'b1;
      hold_count      <= 200;
      m_axis_tready_i <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count      <= hold_count - 1;
      m_axis_tready_i <= 1'b0;
    end else if (accepted_in < 150 || (accepted_in > 700 && accepted_in < 900)) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    log_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.log_value      = m_axis_tdata_o[31:0];
      got.minus_infinity = m_axis_tdata_o[32];
      accepted_out <= accepted_out + 1;
      if (expected_log_q.size() == 0) begin
        $display("%0t: unexpected result log=%h inf=%b", $time,
                 got.log_value, got.minus_infinity);
        error_count <= error_count + 1;
      end else begin
        want = expected_log_q.pop_front();
        if (got.log_value !== want.log_value) begin
          $display("%0t: log_value expected %h actual %h", $time,
                   want.log_value, got.log_value);
          error_count <= error_count + 1;
        end
        if (got.minus_infinity !== want.minus_infinity) begin
          $display("%0t: minus_infinity expected %b actual %b", $time,
                   want.minus_infinity, got.minus_infinity);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction; also ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_log_q.size());
      $display("Some tests failed");
      $finish;
    end else if (stimulus_done) begin
      $display("Ran %0d operands (%0d below one, %0d zero), %0d results checked.",
               accepted_in, neg_count, inf_count, accepted_out);
      if (error_count == 0 && expected_log_q.size() == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
      $finish;
    end
  end

  initial begin
    accepted_in  = 0;
    accepted_out = 0;
    idle_cycles  = 0;
    neg_count    = 0;
    inf_count    = 0;
  end
endmodule
`default_nettype wire

/* natural_log_series_unit.f */
+incdir+rtl
rtl/nlsu_pkg.sv
rtl/natural_log_series_unit.sv
rtl/nlsu_checker.sv
tb/sv/natural_log_series_unit_tb.sv
